### design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is asserted
`define BOM_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, off while reset is asserted
`define BOM_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

// Next-cycle implication that also runs through reset
`define BOM_ASSERT_NXT_ALWAYS(lbl, ck, ante, cons) \
  lbl: assert property (@(posedge ck) (ante) |=> (cons)) \
    else $error("reset-time check failed");

`endif

### design/bom_pkg.sv
package bom_pkg;

  // Fixed field widths
  localparam int SAMPLE_W   = 16;
  localparam int FREQ_W     = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int PHASE_W    = 32;
  localparam int SINE_MAG_W = 15;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TONE_FREQ  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIX_ENABLE = 1'd1;

  localparam logic [FREQ_W-1:0] TONE_FREQ_RESET = 16'd100;

  // Q2.30 constants for the sine polynomial
  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic {
    STEP_IDLE,
    STEP_LOAD
  } step_state_t;

  // Phase step and its status, from the step generator to the datapath
  typedef struct packed {
    logic               busy;
    logic [PHASE_W-1:0] step;
  } step_info_t;

  // First-quadrant sine magnitude, Q15, for point x of 2^(tbits-2) per quarter.
  // Used only on constants to build the table.
  function automatic logic [SINE_MAG_W-1:0] quarter_sine(input int unsigned x,
                                                         input int unsigned tbits);
    logic [63:0] t;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] u;
    logic [63:0] s;
    t  = 64'(x) << (30 - (tbits - 2));
    a  = (t * HALF_PI_Q30) >> 30;
    a2 = (a * a) >> 30;
    // Horner form of the Taylor series, each step truncated
    u  = Q30_ONE - a2 / 64'd72;
    u  = Q30_ONE - ((a2 * u) >> 30) / 64'd42;
    u  = Q30_ONE - ((a2 * u) >> 30) / 64'd20;
    u  = Q30_ONE - ((a2 * u) >> 30) / 64'd6;
    s  = ((a * u) >> 30) >> 15;
    if (s > 64'd32767) begin
      s = 64'd32767;
    end
    return s[SINE_MAG_W-1:0];
  endfunction

endpackage

### design/beat_oscillator_mixer.sv
// Channel | Ports                                 | Direction
// in      | in_valid, in_ready, in_sample_in      | sample words in
// out     | out_valid, out_ready, out_sample_out  | mixed words out
// cfg     | cfg_wr_en, cfg_index, cfg_wdata       | register writes
//
// One word per cycle unless the output stalls or a step is pending; the sine
// table read is registered with the word, the product in the output register.
// A tone_frequency write recomputes the phase step with a reciprocal multiply:
// in_ready is low in the cycle after it.
// Synchronous active-low reset; tone_frequency 100, mixing off, phase 0.
// A stalled output holds its word; input keeps flowing until both stages fill.
module beat_oscillator_mixer
  import bom_pkg::*;
#(
  parameter int SAMPLE_RATE     = 48000,
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] in_sample_in,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] out_sample_out,
  input  logic                       cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_wdata
);

  logic [FREQ_W-1:0]          tone_freq_r;
  logic                       mix_en_r;
  logic [PHASE_W-1:0]         phase_r;
  logic                       s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_W-1:0] s1_sample_r;
  logic                       s1_mix_r;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_W-1:0] out_sample_r, out_sample_nxt;

  step_info_t                   step_info;
  logic signed [SAMPLE_W-1:0]   sine_r;
  logic signed [2*SAMPLE_W-1:0] prod;
  logic                         freq_nz;
  logic                         step_start;
  logic                         in_acc;
  logic                         out_adv;
  logic                         s1_move;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tone_freq_r <= TONE_FREQ_RESET;
      mix_en_r    <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_TONE_FREQ:  tone_freq_r <= cfg_wdata[FREQ_W-1:0];
        REG_MIX_ENABLE: mix_en_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign step_start = cfg_wr_en && (cfg_index == REG_TONE_FREQ);

  bom_step_gen #(
    .SAMPLE_RATE(SAMPLE_RATE)
  ) u_step (
    .clk  (clk),
    .rst_n(rst_n),
    .start(step_start),
    .freq (cfg_wdata[FREQ_W-1:0]),
    .info (step_info)
  );

  // Handshake
  assign freq_nz  = (tone_freq_r != '0);
  assign out_adv  = !out_valid_r || out_ready;
  assign s1_move  = s1_valid_r && out_adv;
  assign in_ready = !step_info.busy && (!s1_valid_r || out_adv);
  assign in_acc   = in_valid && in_ready;

  // Oscillator: sine is read at the phase before the word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= '0;
    end else if (in_acc && freq_nz) begin
      phase_r <= phase_r + step_info.step;
    end
  end

  bom_sine_rom #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS)
  ) u_sine (
    .clk   (clk),
    .load  (in_acc),
    .phase (phase_r),
    .sine_r(sine_r)
  );

  // Input stage
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_move) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_sample_r <= in_sample_in;
      s1_mix_r    <= mix_en_r && freq_nz;
    end
  end

  // Q1.15 product, floor of prod / 2^15
  assign prod           = s1_sample_r * sine_r;
  assign out_sample_nxt = s1_mix_r ? prod[2*SAMPLE_W-2 -: SAMPLE_W] : s1_sample_r;

  // Output stage
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_move) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      out_sample_r <= out_sample_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;

endmodule

### design/bom_step_gen.sv
// Phase step = floor(freq * 2^32 / SAMPLE_RATE) mod 2^32, split as
// freq * Q + floor(freq * R / SAMPLE_RATE) with Q, R the quotient and
// remainder of 2^32 / SAMPLE_RATE. The second term is freq times
// ceil(R * 2^SH / SAMPLE_RATE), shifted right by SH = 16 + clog2(SAMPLE_RATE),
// which is exact for every 16-bit freq.
// Both products are registered on the write, their sum in the cycle after.
module bom_step_gen
  import bom_pkg::*;
#(
  parameter int SAMPLE_RATE = 48000
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [FREQ_W-1:0] freq,
  output step_info_t        info
);

  localparam logic [63:0] TWO32 = 64'd1 << 32;
  localparam int RW = $clog2(SAMPLE_RATE);
  localparam int SH = FREQ_W + RW;
  localparam int MW = FREQ_W + SH;
  localparam logic [PHASE_W-1:0] STEP_Q = PHASE_W'(TWO32 / SAMPLE_RATE);
  localparam logic [63:0]        STEP_R = TWO32 % SAMPLE_RATE;
  localparam logic [SH-1:0]      RECIP_R =
    SH'(((STEP_R << SH) + 64'(SAMPLE_RATE - 1)) / 64'(SAMPLE_RATE));
  localparam logic [PHASE_W-1:0] STEP_RESET =
    PHASE_W'((64'(TONE_FREQ_RESET) << 32) / SAMPLE_RATE);

  step_state_t        state_r, state_nxt;
  logic [PHASE_W-1:0] fq_r;
  logic [MW-1:0]      fm_r;
  logic [PHASE_W-1:0] step_r;

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      STEP_IDLE: state_nxt = STEP_IDLE;
      STEP_LOAD: state_nxt = STEP_IDLE;
      default:   state_nxt = STEP_IDLE;
    endcase
    if (start) begin
      state_nxt = STEP_LOAD;
    end
  end

  // Outputs
  always_comb begin
    info.busy = (state_r != STEP_IDLE);
    info.step = step_r;
  end

  // Control and the live step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= STEP_IDLE;
      step_r  <= STEP_RESET;
    end else begin
      state_r <= state_nxt;
      if (state_r == STEP_LOAD) begin
        step_r <= fq_r + PHASE_W'(fm_r[MW-1 -: FREQ_W]);
      end
    end
  end

  // Products of the new frequency
  always_ff @(posedge clk) begin
    if (start) begin
      fq_r <= PHASE_W'(freq) * STEP_Q;
      fm_r <= MW'(freq) * MW'(RECIP_R);
    end
  end

endmodule

### design/bom_sine_rom.sv
// Quarter-wave sine table with registered read. The top table bits of the
// phase pick a point; the quadrant folds it and sets the sign.
module bom_sine_rom
  import bom_pkg::*;
#(
  parameter int SINE_TABLE_BITS = 10
) (
  input  logic                       clk,
  input  logic                       load,
  input  logic [PHASE_W-1:0]         phase,
  output logic signed [SAMPLE_W-1:0] sine_r
);

  localparam int SPAN = 1 << (SINE_TABLE_BITS - 2);
  localparam int XW   = SINE_TABLE_BITS - 1;

  logic [SINE_MAG_W-1:0] qtab [SPAN + 1];

  logic [SINE_TABLE_BITS-1:0] k;
  logic [1:0]                 quad;
  logic [SINE_TABLE_BITS-3:0] r;
  logic [XW-1:0]              x;
  logic signed [SAMPLE_W-1:0] mag_s;
  logic signed [SAMPLE_W-1:0] sine_nxt;

  // Table contents, fixed at elaboration
  for (genvar i = 0; i <= SPAN; i++) begin : g_tab
    assign qtab[i] = quarter_sine(i, SINE_TABLE_BITS);
  end

  // Fold into the first quadrant
  assign k    = phase[PHASE_W-1 -: SINE_TABLE_BITS];
  assign quad = k[SINE_TABLE_BITS-1 -: 2];
  assign r    = k[SINE_TABLE_BITS-3:0];
  assign x    = quad[0] ? (XW'(SPAN) - XW'(r)) : XW'(r);

  // Lower half-cycle is negative
  assign mag_s    = signed'(SAMPLE_W'(qtab[x]));
  assign sine_nxt = quad[1] ? -mag_s : mag_s;

  always_ff @(posedge clk) begin
    if (load) begin
      sine_r <= sine_nxt;
    end
  end

endmodule

### design/bom_checker.sv
`include "assert_macros.svh"

// Port-level checks on the mixer
module bom_checker
  import bom_pkg::*;
(
  input logic                       clk,
  input logic                       rst_n,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] out_sample_out,
  input logic                       cfg_wr_en,
  input logic [CFG_IDX_W-1:0]       cfg_index
);

  // A stalled result word holds
  `BOM_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_sample_out))

  // Reset empties the output register
  `BOM_ASSERT_NXT_ALWAYS(a_rst_empty, clk, !rst_n, !out_valid)

  // New frequency: no input taken while the step is being recomputed
  `BOM_ASSERT_NXT(a_step_busy, clk, rst_n, cfg_wr_en && (cfg_index == REG_TONE_FREQ), !in_ready)

endmodule

bind beat_oscillator_mixer bom_checker u_bom_checker (.*);

### test/tb_beat_oscillator_mixer.sv
`timescale 1ns / 1ps

module tb_beat_oscillator_mixer;
  import bom_pkg::*;

  localparam int SAMPLE_RATE_HZ = 48000;
  localparam int TABLE_BITS     = 10;
  localparam int QUARTER_SPAN   = 1 << (TABLE_BITS - 2);
  localparam longint unsigned ONE_Q30     = 64'd1073741824;
  localparam longint unsigned HALF_PI_Q30V = 64'd1686629713;
  localparam int SETTLE_CYCLES  = 4;

  logic                       clk = 1'b0;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic                       cfg_wr_en;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [CFG_DATA_W-1:0]      cfg_wdata;

  // Mirror of the block's registers and oscillator
  logic [FREQ_W-1:0]  model_freq;
  logic               model_mix;
  logic [PHASE_W-1:0] model_phase;

  logic signed [SAMPLE_W-1:0] mixed_words_due[$];

  int fault_count = 0;
  bit gaps_on;
  int hold_len;

  beat_oscillator_mixer #(
    .SAMPLE_RATE     (SAMPLE_RATE_HZ),
    .SINE_TABLE_BITS (TABLE_BITS)
  ) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_sample_in   (in_sample_in),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sample_out (out_sample_out),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata)
  );

  always #4 clk = ~clk;

  // Fixed-point sine of the oscillator phase, Q1.15, never -32768
  function automatic int tone_sine(input logic [PHASE_W-1:0] ph);
    logic [TABLE_BITS-1:0] k;
    logic [1:0]            quad;
    longint unsigned       x;
    longint unsigned       t;
    longint unsigned       a;
    longint unsigned       a2;
    longint unsigned       u;
    longint unsigned       s;
    k    = ph[PHASE_W-1 -: TABLE_BITS];
    quad = k[TABLE_BITS-1 -: 2];
    x    = 64'(k[TABLE_BITS-3:0]);
    if (quad[0]) begin
      x = QUARTER_SPAN - x;
    end
    t  = x << (30 - (TABLE_BITS - 2));
    a  = (t * HALF_PI_Q30V) >> 30;
    a2 = (a * a) >> 30;
    // Taylor series up to a^9, nested, every step truncated
    u  = ONE_Q30 - a2 / 72;
    u  = ONE_Q30 - ((a2 * u) >> 30) / 42;
    u  = ONE_Q30 - ((a2 * u) >> 30) / 20;
    u  = ONE_Q30 - ((a2 * u) >> 30) / 6;
    s  = ((a * u) >> 30) >> 15;
    if (s > 32767) begin
      s = 32767;
    end
    return quad[1] ? -int'(s) : int'(s);
  endfunction

  function automatic logic [PHASE_W-1:0] phase_step(input logic [FREQ_W-1:0] f);
    longint unsigned n;
    n = (longint'(f) << 32) / SAMPLE_RATE_HZ;
    return n[PHASE_W-1:0];
  endfunction

  // Expected output word for one accepted sample; advances the phase
  task automatic mix_sample(input logic signed [SAMPLE_W-1:0] smp);
    logic signed [SAMPLE_W-1:0] res;
    longint                     prod;
    res = smp;
    if (model_freq != 0) begin
      if (model_mix) begin
        prod = longint'(smp) * longint'(tone_sine(model_phase));
        prod = prod >>> 15;
        res  = prod[SAMPLE_W-1:0];
      end
      model_phase = model_phase + phase_step(model_freq);
    end
    mixed_words_due.push_back(res);
  endtask

  // Offer one sample word and wait until it is taken
  task automatic send_word(input logic signed [SAMPLE_W-1:0] smp);
    int gap;
    gap = gaps_on ? $urandom_range(0, 11) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_sample_in <= smp;
    do @(posedge clk); while (!in_ready);
    mix_sample(smp);
  endtask

  // Stop offering and wait until every expected word has come back
  task automatic drain_words();
    @(negedge clk);
    in_valid <= 1'b0;
    while (mixed_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    drain_words();
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == REG_TONE_FREQ) begin
      model_freq = data;
    end else if (idx == REG_MIX_ENABLE) begin
      model_mix = data[0];
    end
  endtask

  function automatic logic signed [SAMPLE_W-1:0] random_sample();
    case ($urandom_range(0, 11))
      0:       return 16'sh8000;
      1:       return 16'sh7fff;
      2:       return 16'sh0000;
      3:       return 16'shffff;
      default: return 16'($urandom);
    endcase
  endfunction

  // Reset values: 100 Hz, mixing off, so words pass while the phase runs
  task automatic test_reset_defaults();
    send_word(16'sh1234);
    send_word(16'sh8000);
    send_word(16'sh7fff);
    send_word(16'sh0000);
  endtask

  // Quarter-cycle step lands on the sine peaks and zero crossings,
  // including the largest product
  task automatic test_quarter_points();
    logic signed [SAMPLE_W-1:0] pts[10];
    pts = '{16'sh8000, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh7fff,
            16'sh0000, 16'shffff, 16'sh0001, 16'sh5555, 16'shaaaa};
    write_register(REG_TONE_FREQ, 16'd12000);
    write_register(REG_MIX_ENABLE, 16'h0001);
    foreach (pts[i]) send_word(pts[i]);
  endtask

  // Zero frequency passes words and holds the phase, mixing on or off
  task automatic test_zero_frequency();
    write_register(REG_TONE_FREQ, 16'd0);
    send_word(16'sh8000);
    send_word(16'sh7fff);
    write_register(REG_MIX_ENABLE, 16'hfffe);
    send_word(16'sh4321);
    write_register(REG_MIX_ENABLE, 16'h8001);
    write_register(REG_TONE_FREQ, 16'd1);
    send_word(16'sh7fff);
  endtask

  task automatic test_max_frequency();
    write_register(REG_TONE_FREQ, 16'hffff);
    send_word(16'sh8000);
    send_word(16'sh7fff);
    send_word(16'sh2aaa);
  endtask

  // Random settings, random words; some phases without any idling
  task automatic test_random_mixing();
    logic [FREQ_W-1:0] f;
    int                n;
    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0:       f = 16'hffff;
        1:       f = 16'd0;
        2:       f = 16'd1;
        default: begin
          case ($urandom_range(0, 3))
            0:       f = 16'($urandom_range(1, 2000));
            1:       f = ($urandom_range(0, 1) != 0) ? 16'd12000 : 16'd24000;
            default: f = 16'($urandom);
          endcase
        end
      endcase
      write_register(REG_TONE_FREQ, f);
      write_register(REG_MIX_ENABLE,
                     {15'($urandom), 1'($urandom_range(0, 3) != 0)});
      gaps_on = (ph % 3) != 2;
      if (ph == 4) begin
        hold_len = 70;
      end
      n = $urandom_range(135, 155);
      repeat (n) send_word(random_sample());
    end
    gaps_on = 1'b1;
  endtask

  // Receiver holds off while words keep coming, so the input stalls
  task automatic test_backpressure();
    write_register(REG_TONE_FREQ, 16'($urandom));
    write_register(REG_MIX_ENABLE, 16'h0001);
    gaps_on  = 1'b0;
    hold_len = 80;
    repeat (30) send_word(random_sample());
    gaps_on = 1'b1;
  endtask

  // Receiver: random stalls, or a long hold-off when asked
  initial begin
    int n;
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_len > 0) begin
        n        = hold_len;
        hold_len = 0;
      end else begin
        n = gaps_on ? $urandom_range(0, 11) : 0;
      end
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Compare each delivered word with the oldest expected one
  always @(posedge clk) begin
    logic signed [SAMPLE_W-1:0] want;
    if (rst_n && out_valid && out_ready) begin
      if (mixed_words_due.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) begin
          $display("%0t: unexpected word sample_out=%0d", $realtime, out_sample_out);
        end
      end else begin
        want = mixed_words_due.pop_front();
        if (out_sample_out !== want) begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("%0t: sample_out mismatch: expected %0d, got %0d",
                     $realtime, want, out_sample_out);
          end
        end
      end
    end
  end

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_sample_in = '0;
    cfg_wr_en    = 1'b0;
    cfg_index    = REG_TONE_FREQ;
    cfg_wdata    = '0;
    model_freq   = TONE_FREQ_RESET;
    model_mix    = 1'b0;
    model_phase  = '0;
    gaps_on      = 1'b1;
    hold_len     = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_quarter_points();
    test_zero_frequency();
    test_max_frequency();
    test_random_mixing();
    test_backpressure();

    drain_words();
    repeat (10) @(posedge clk);
    if (fault_count == 0 && mixed_words_due.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL");
    $finish;
  end

endmodule
